@@ design/rtmp_chunk_header_parser_top_defines.svh @@
// ----------------------------------------------------------------------------
// rtmp chunk header parser assertion macros
// shared concurrent assertion forms for the parser modules
// ----------------------------------------------------------------------------
`ifndef RTMP_CHUNK_HEADER_PARSER_TOP_DEFINES_SVH
`define RTMP_CHUNK_HEADER_PARSER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RTMP_CHP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define RTMP_CHP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/rtmp_chp_pkg.sv @@
// ----------------------------------------------------------------------------
// rtmp chunk header parser package
// header formats, field widths, length table and result type
// ----------------------------------------------------------------------------
package rtmp_chp_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned FMT_W     = 2;
   localparam int unsigned CHANNEL_W = 17;
   localparam int unsigned TS_W      = 24;
   localparam int unsigned BODY_W    = 24;
   localparam int unsigned TYPE_W    = 8;
   localparam int unsigned STREAM_W  = 32;
   localparam int unsigned LEN_W     = 4;
   localparam int unsigned EXT_W     = 2;

   typedef enum logic [FMT_W-1:0] {
      FMT_FULL      = 2'd0,
      FMT_NO_STREAM = 2'd1,
      FMT_TS_ONLY   = 2'd2,
      FMT_BASIC     = 2'd3
   } fmt_type;

   localparam logic [LEN_W-1:0] LEN_FULL      = 4'd12;
   localparam logic [LEN_W-1:0] LEN_NO_STREAM = 4'd8;
   localparam logic [LEN_W-1:0] LEN_TS_ONLY   = 4'd4;
   localparam logic [LEN_W-1:0] LEN_BASIC     = 4'd1;

   // channel field codes in the first byte
   localparam logic [5:0] CHAN_EXT_ONE = 6'd0;
   localparam logic [5:0] CHAN_EXT_TWO = 6'd1;

   localparam logic [CHANNEL_W-1:0] CHANNEL_BASE    = 17'd64;
   localparam logic [CHANNEL_W-1:0] CHANNEL_INVALID = '1;

   typedef struct packed {
      logic [FMT_W-1:0]     header_format;
      logic [CHANNEL_W-1:0] channel_id;
      logic [TS_W-1:0]      timestamp;
      logic [BODY_W-1:0]    body_length;
      logic [TYPE_W-1:0]    message_type;
      logic [STREAM_W-1:0]  stream_id;
      logic [LEN_W-1:0]     header_bytes;
   } result_type;

   function automatic logic [LEN_W-1:0] base_len(input logic [FMT_W-1:0] fmt);
      logic [LEN_W-1:0] len;
      unique case (fmt_type'(fmt))
         FMT_FULL:      len = LEN_FULL;
         FMT_NO_STREAM: len = LEN_NO_STREAM;
         FMT_TS_ONLY:   len = LEN_TS_ONLY;
         FMT_BASIC:     len = LEN_BASIC;
         default:       len = LEN_BASIC;
      endcase
      return len;
   endfunction

endpackage

@@ design/rtmp_chp_req_if.sv @@
// ----------------------------------------------------------------------------
// rtmp chunk header parser request channel
// one raw header byte per request
// ----------------------------------------------------------------------------
interface rtmp_chp_req_if;
   logic                              valid;
   logic                              ready;
   logic [rtmp_chp_pkg::BYTE_W-1:0]   data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

@@ design/rtmp_chp_rsp_if.sv @@
// ----------------------------------------------------------------------------
// rtmp chunk header parser result channel
// one decoded chunk header per result
// ----------------------------------------------------------------------------
interface rtmp_chp_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [rtmp_chp_pkg::FMT_W-1:0]       header_format;
   logic [rtmp_chp_pkg::CHANNEL_W-1:0]   channel_id;
   logic [rtmp_chp_pkg::TS_W-1:0]        timestamp;
   logic [rtmp_chp_pkg::BODY_W-1:0]      body_length;
   logic [rtmp_chp_pkg::TYPE_W-1:0]      message_type;
   logic [rtmp_chp_pkg::STREAM_W-1:0]    stream_id;
   logic [rtmp_chp_pkg::LEN_W-1:0]       header_bytes;

   modport source (output valid, output header_format, output channel_id,
                   output timestamp, output body_length, output message_type,
                   output stream_id, output header_bytes, input ready);
   modport sink   (input valid, input header_format, input channel_id,
                   input timestamp, input body_length, input message_type,
                   input stream_id, input header_bytes, output ready);
endinterface

@@ design/rtmp_chp_decode.sv @@
// ----------------------------------------------------------------------------
// rtmp chunk header decoder
// byte position tracking and field assembly, flags the last header byte
// ----------------------------------------------------------------------------
`include "rtmp_chunk_header_parser_top_defines.svh"

module rtmp_chp_decode (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              byte_accept,
   input  logic [rtmp_chp_pkg::BYTE_W-1:0]   data_byte,
   output logic                              hdr_done,
   output rtmp_chp_pkg::result_type          hdr_result
);

   logic [rtmp_chp_pkg::LEN_W-1:0]     pos_ff, pos_in;
   logic [rtmp_chp_pkg::FMT_W-1:0]     fmt_ff, fmt_in;
   logic [rtmp_chp_pkg::CHANNEL_W-1:0] chan_ff, chan_in;
   logic [rtmp_chp_pkg::EXT_W-1:0]     ext_ff, ext_in;
   logic [rtmp_chp_pkg::TS_W-1:0]      ts_ff, ts_in;
   logic [rtmp_chp_pkg::BODY_W-1:0]    body_ff, body_in;
   logic [rtmp_chp_pkg::TYPE_W-1:0]    type_ff, type_in;
   logic [rtmp_chp_pkg::STREAM_W-1:0]  stream_ff, stream_in;

   logic [rtmp_chp_pkg::LEN_W-1:0]     field_pos;
   logic [rtmp_chp_pkg::LEN_W-1:0]     total_len;
   logic [rtmp_chp_pkg::LEN_W:0]       pos_next;
   logic                               last_byte;

   always_comb begin
      fmt_in    = fmt_ff;
      chan_in   = chan_ff;
      ext_in    = ext_ff;
      ts_in     = ts_ff;
      body_in   = body_ff;
      type_in   = type_ff;
      stream_in = stream_ff;
      field_pos = pos_ff - {2'b00, ext_ff};

      if (pos_ff == '0) begin
         fmt_in = data_byte[7:6];
         if (data_byte[5:0] == rtmp_chp_pkg::CHAN_EXT_ONE) begin
            ext_in  = 2'd1;
            chan_in = rtmp_chp_pkg::CHANNEL_BASE;
         end else if (data_byte[5:0] == rtmp_chp_pkg::CHAN_EXT_TWO) begin
            ext_in  = 2'd2;
            chan_in = rtmp_chp_pkg::CHANNEL_BASE;
         end else begin
            ext_in  = 2'd0;
            chan_in = {11'd0, data_byte[5:0]};
         end
      end else if (pos_ff <= {2'b00, ext_ff}) begin
         // little-endian extension on top of the base of 64
         if (pos_ff == 4'd1) begin
            chan_in = chan_ff + {9'd0, data_byte};
         end else begin
            chan_in = chan_ff + {1'b0, data_byte, 8'd0};
         end
      end else if (field_pos <= 4'd3) begin
         ts_in = {ts_ff[15:0], data_byte};
      end else if (field_pos <= 4'd6) begin
         body_in = {body_ff[15:0], data_byte};
      end else if (field_pos == 4'd7) begin
         type_in = data_byte;
      end else if (field_pos <= 4'd11) begin
         case (field_pos[1:0])
            2'd0:    stream_in[7:0]   = data_byte;
            2'd1:    stream_in[15:8]  = data_byte;
            2'd2:    stream_in[23:16] = data_byte;
            default: stream_in[31:24] = data_byte;
         endcase
      end

      total_len = rtmp_chp_pkg::base_len(fmt_in) + {2'b00, ext_in};
      pos_next  = {1'b0, pos_ff} + 5'd1;
      last_byte = pos_next >= {1'b0, total_len};
      pos_in    = last_byte ? '0 : pos_next[rtmp_chp_pkg::LEN_W-1:0];
   end

   assign hdr_done = byte_accept && last_byte;

   always_comb begin
      hdr_result.header_format = fmt_in;
      hdr_result.channel_id    = chan_in;
      hdr_result.timestamp     = ts_in;
      hdr_result.body_length   = body_in;
      hdr_result.message_type  = type_in;
      hdr_result.stream_id     = stream_in;
      hdr_result.header_bytes  = total_len;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         fmt_ff    <= '0;
         chan_ff   <= rtmp_chp_pkg::CHANNEL_INVALID;
         ext_ff    <= '0;
         ts_ff     <= '0;
         body_ff   <= '0;
         type_ff   <= '0;
         stream_ff <= '0;
      end else if (byte_accept) begin
         pos_ff    <= pos_in;
         fmt_ff    <= fmt_in;
         chan_ff   <= chan_in;
         ext_ff    <= ext_in;
         ts_ff     <= ts_in;
         body_ff   <= body_in;
         type_ff   <= type_in;
         stream_ff <= stream_in;
      end
   end

   `RTMP_CHP_ASSERT_NOW(a_pos_range, clock, reset, 1'b1, pos_ff < 4'd14, "byte position past header end")
   `RTMP_CHP_ASSERT_NOW(a_ext_range, clock, reset, 1'b1, ext_ff != 2'd3, "bad extension byte count")
   `RTMP_CHP_ASSERT_NEXT(a_done_rewinds, clock, reset, hdr_done, pos_ff == '0, "position not cleared after header")

endmodule

@@ design/rtmp_chp_outbuf.sv @@
// ----------------------------------------------------------------------------
// rtmp chunk header result buffer
// output register plus skid entry so bytes keep flowing while a result waits
// ----------------------------------------------------------------------------
`include "rtmp_chunk_header_parser_top_defines.svh"

module rtmp_chp_outbuf (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  rtmp_chp_pkg::result_type   in_data,
   output logic                       in_ready,
   output logic                       out_valid,
   output rtmp_chp_pkg::result_type   out_data,
   input  logic                       out_ready
);

   logic                     main_valid_ff;
   logic                     skid_valid_ff;
   rtmp_chp_pkg::result_type main_ff;
   rtmp_chp_pkg::result_type skid_ff;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!main_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            // no new request can arrive while the skid entry is full
            main_valid_ff <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            main_valid_ff <= in_valid;
         end
      end else if (in_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!main_valid_ff || out_ready) begin
         main_ff <= skid_valid_ff ? skid_ff : in_data;
      end else if (in_valid) begin
         skid_ff <= in_data;
      end
   end

   `RTMP_CHP_ASSERT_NOW(a_skid_behind_main, clock, reset, skid_valid_ff, main_valid_ff, "skid entry full with output empty")
   `RTMP_CHP_ASSERT_NOW(a_no_overrun, clock, reset, in_valid, !skid_valid_ff, "result arrived with buffer full")
   `RTMP_CHP_ASSERT_NEXT(a_stall_to_skid, clock, reset, main_valid_ff && !out_ready && in_valid, skid_valid_ff, "stalled result not held in skid entry")

endmodule

@@ design/rtmp_chunk_header_parser_top.sv @@
// ----------------------------------------------------------------------------
// rtmp chunk header parser top level
// parses rtmp chunk headers one byte per request into decoded header results
// ----------------------------------------------------------------------------
// Takes one header byte per cycle with no gaps needed, while the result buffer
// has room. A header of 1 to 14 bytes produces one result, registered into the
// output register and offered from it; while that register holds a result the
// sink has not taken, the new result waits in the skid entry. The two entries
// decouple the sides: the byte side stalls only while both hold results that the
// sink has not taken. Fields a short header format leaves out report stored values.
module rtmp_chunk_header_parser_top (
   input  logic             clock,
   input  logic             reset,
   rtmp_chp_req_if.sink     req_if,
   rtmp_chp_rsp_if.source   rsp_if
);

   logic                     byte_accept;
   logic                     hdr_done;
   logic                     buf_ready;
   rtmp_chp_pkg::result_type hdr_result;
   rtmp_chp_pkg::result_type rsp_data;

   assign req_if.ready = buf_ready;
   assign byte_accept  = req_if.valid && buf_ready;

   rtmp_chp_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (byte_accept),
      .data_byte   (req_if.data_byte),
      .hdr_done    (hdr_done),
      .hdr_result  (hdr_result)
   );

   rtmp_chp_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (hdr_done),
      .in_data   (hdr_result),
      .in_ready  (buf_ready),
      .out_valid (rsp_if.valid),
      .out_data  (rsp_data),
      .out_ready (rsp_if.ready)
   );

   assign rsp_if.header_format = rsp_data.header_format;
   assign rsp_if.channel_id    = rsp_data.channel_id;
   assign rsp_if.timestamp     = rsp_data.timestamp;
   assign rsp_if.body_length   = rsp_data.body_length;
   assign rsp_if.message_type  = rsp_data.message_type;
   assign rsp_if.stream_id     = rsp_data.stream_id;
   assign rsp_if.header_bytes  = rsp_data.header_bytes;

endmodule

@@ tb/rtmp_chunk_header_parser_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rtmp chunk header parser testbench
// feeds directed and random chunk headers byte by byte, decodes each byte in
// a local model of the parser and checks every result field against it
// ----------------------------------------------------------------------------
module rtmp_chunk_header_parser_top_tb;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 20;
   localparam int ITEM_TARGET    = 850;
   localparam int HOLD_CYCLES    = 80;
   localparam int HOLD_AT_RESULT = 20;

   localparam logic [rtmp_chp_pkg::LEN_W-1:0] FMT_LENGTH [4] =
      '{rtmp_chp_pkg::LEN_FULL, rtmp_chp_pkg::LEN_NO_STREAM,
        rtmp_chp_pkg::LEN_TS_ONLY, rtmp_chp_pkg::LEN_BASIC};

   typedef enum {FILL_ZERO, FILL_ONES, FILL_RANDOM} fill_type;

   logic clock;
   logic reset;

   rtmp_chp_req_if req_ch ();
   rtmp_chp_rsp_if rsp_ch ();

   rtmp_chunk_header_parser_top DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // bytes waiting to be sent and decoded headers waiting to come out
   logic [rtmp_chp_pkg::BYTE_W-1:0] byte_queue [$];
   rtmp_chp_pkg::result_type        pending_headers [$];

   // local copy of the parser state
   logic [3:0]                         hdr_pos;
   rtmp_chp_pkg::fmt_type              hdr_fmt;
   logic [rtmp_chp_pkg::CHANNEL_W-1:0] hdr_chan;
   logic [rtmp_chp_pkg::EXT_W-1:0]     hdr_ext;
   logic [rtmp_chp_pkg::TS_W-1:0]      hdr_ts;
   logic [rtmp_chp_pkg::BODY_W-1:0]    hdr_body;
   logic [rtmp_chp_pkg::TYPE_W-1:0]    hdr_type;
   logic [rtmp_chp_pkg::STREAM_W-1:0]  hdr_stream;

   int total_bytes;
   int bytes_sent;
   int headers_checked;
   int error_count;
   int idle_cycles;
   int hold_left;
   bit hold_done;
   int fmt_seen [4];

   always #5 clock = ~clock;

   function automatic logic [rtmp_chp_pkg::BYTE_W-1:0] fill_byte(input fill_type fill);
      int r;
      r = $urandom_range(9);
      case (fill)
         FILL_ZERO: return '0;
         FILL_ONES: return '1;
         default: begin
            if (r == 0) return '0;
            if (r == 1) return '1;
            return rtmp_chp_pkg::BYTE_W'($urandom_range(255));
         end
      endcase
   endfunction

   task automatic add_header(input rtmp_chp_pkg::fmt_type f, input logic [5:0] low,
                             input fill_type fill);
      int n;
      n = FMT_LENGTH[f] - 1;
      if (low == rtmp_chp_pkg::CHAN_EXT_ONE) n = n + 1;
      else if (low == rtmp_chp_pkg::CHAN_EXT_TWO) n = n + 2;
      byte_queue.push_back({f, low});
      repeat (n) byte_queue.push_back(fill_byte(fill));
   endtask

   task automatic decode_header_byte(input logic [rtmp_chp_pkg::BYTE_W-1:0] b);
      int unsigned q;
      logic [rtmp_chp_pkg::LEN_W-1:0] total;
      rtmp_chp_pkg::result_type hdr;
      if (hdr_pos == 0) begin
         hdr_fmt = rtmp_chp_pkg::fmt_type'(b[7:6]);
         if (b[5:0] == rtmp_chp_pkg::CHAN_EXT_ONE) begin
            hdr_ext  = 1;
            hdr_chan = rtmp_chp_pkg::CHANNEL_BASE;
         end else if (b[5:0] == rtmp_chp_pkg::CHAN_EXT_TWO) begin
            hdr_ext  = 2;
            hdr_chan = rtmp_chp_pkg::CHANNEL_BASE;
         end else begin
            hdr_ext  = 0;
            hdr_chan = rtmp_chp_pkg::CHANNEL_W'(b[5:0]);
         end
      end else if (hdr_pos <= hdr_ext) begin
         // channel extension, low byte first
         hdr_chan = hdr_chan + (rtmp_chp_pkg::CHANNEL_W'(b) << (8 * (hdr_pos - 1)));
      end else begin
         q = hdr_pos - hdr_ext;
         if (q <= 3) hdr_ts = {hdr_ts[rtmp_chp_pkg::TS_W-9:0], b};
         else if (q <= 6) hdr_body = {hdr_body[rtmp_chp_pkg::BODY_W-9:0], b};
         else if (q == 7) hdr_type = b;
         else if (q <= 11) hdr_stream[8 * (q - 8) +: 8] = b;
      end
      total = FMT_LENGTH[hdr_fmt] + hdr_ext;
      if (hdr_pos + 1 >= total) begin
         hdr.header_format = hdr_fmt;
         hdr.channel_id    = hdr_chan;
         hdr.timestamp     = hdr_ts;
         hdr.body_length   = hdr_body;
         hdr.message_type  = hdr_type;
         hdr.stream_id     = hdr_stream;
         hdr.header_bytes  = total;
         pending_headers.push_back(hdr);
         hdr_pos = 0;
      end else begin
         hdr_pos = hdr_pos + 1;
      end
   endtask

   task automatic check_header();
      rtmp_chp_pkg::result_type exp;
      if (pending_headers.size() == 0) begin
         $error("unexpected header result: channel_id %0d", rsp_ch.channel_id);
         error_count++;
         return;
      end
      exp = pending_headers.pop_front();
      headers_checked++;
      fmt_seen[exp.header_format]++;
      if (rsp_ch.header_format !== exp.header_format) begin
         $error("header_format: expected %0d, got %0d", exp.header_format,
                rsp_ch.header_format);
         error_count++;
      end
      if (rsp_ch.channel_id !== exp.channel_id) begin
         $error("channel_id: expected %0d, got %0d", exp.channel_id, rsp_ch.channel_id);
         error_count++;
      end
      if (rsp_ch.timestamp !== exp.timestamp) begin
         $error("timestamp: expected %0h, got %0h", exp.timestamp, rsp_ch.timestamp);
         error_count++;
      end
      if (rsp_ch.body_length !== exp.body_length) begin
         $error("body_length: expected %0h, got %0h", exp.body_length, rsp_ch.body_length);
         error_count++;
      end
      if (rsp_ch.message_type !== exp.message_type) begin
         $error("message_type: expected %0h, got %0h", exp.message_type,
                rsp_ch.message_type);
         error_count++;
      end
      if (rsp_ch.stream_id !== exp.stream_id) begin
         $error("stream_id: expected %0h, got %0h", exp.stream_id, rsp_ch.stream_id);
         error_count++;
      end
      if (rsp_ch.header_bytes !== exp.header_bytes) begin
         $error("header_bytes: expected %0d, got %0d", exp.header_bytes,
                rsp_ch.header_bytes);
         error_count++;
      end
   endtask

   // byte driver
   always @(posedge clock) begin
      int idle_pct;
      if (reset) begin
         req_ch.valid     <= 1'b0;
         req_ch.data_byte <= '0;
      end else begin
         if (bytes_sent < total_bytes / 3) idle_pct = 12;
         else if (bytes_sent < 2 * total_bytes / 3) idle_pct = 48;
         else idle_pct = 0;
         if (req_ch.valid && req_ch.ready) begin
            decode_header_byte(req_ch.data_byte);
            bytes_sent++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (byte_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
               req_ch.valid     <= 1'b1;
               req_ch.data_byte <= byte_queue.pop_front();
            end else begin
               req_ch.valid     <= 1'b0;
               req_ch.data_byte <= rtmp_chp_pkg::BYTE_W'($urandom_range(255));
            end
         end
      end
   end

   // result monitor and receiver
   always @(posedge clock) begin
      int idle_pct;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (bytes_sent < total_bytes / 3) idle_pct = 48;
         else if (bytes_sent < 2 * total_bytes / 3) idle_pct = 12;
         else idle_pct = 0;
         if (rsp_ch.valid && rsp_ch.ready) check_header();
         // one long hold-off so both result entries fill and the byte side stalls
         if (!hold_done && headers_checked == HOLD_AT_RESULT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no request or result accepted for %0d cycles", WATCHDOG_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      rtmp_chp_pkg::fmt_type f;
      int mode;
      logic [5:0] low;
      clock            = 1'b0;
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.data_byte = '0;
      rsp_ch.ready     = 1'b0;
      hdr_pos          = '0;
      hdr_fmt          = rtmp_chp_pkg::FMT_FULL;
      hdr_chan         = rtmp_chp_pkg::CHANNEL_INVALID;
      hdr_ext          = '0;
      hdr_ts           = '0;
      hdr_body         = '0;
      hdr_type         = '0;
      hdr_stream       = '0;
      bytes_sent       = 0;
      headers_checked  = 0;
      error_count      = 0;
      idle_cycles      = 0;
      hold_left        = 0;
      hold_done        = 1'b0;
      fmt_seen         = '{0, 0, 0, 0};

      // single-byte header first, so absent fields show their reset zeros
      add_header(rtmp_chp_pkg::FMT_BASIC, 6'd2, FILL_ZERO);
      add_header(rtmp_chp_pkg::FMT_FULL, rtmp_chp_pkg::CHAN_EXT_TWO, FILL_ONES);
      add_header(rtmp_chp_pkg::FMT_NO_STREAM, rtmp_chp_pkg::CHAN_EXT_ONE, FILL_ZERO);
      add_header(rtmp_chp_pkg::FMT_TS_ONLY, 6'd63, FILL_ONES);

      while (byte_queue.size() < ITEM_TARGET) begin
         f    = rtmp_chp_pkg::fmt_type'($urandom_range(3));
         mode = $urandom_range(9);
         if (mode < 3) low = rtmp_chp_pkg::CHAN_EXT_ONE;
         else if (mode < 5) low = rtmp_chp_pkg::CHAN_EXT_TWO;
         else low = 6'($urandom_range(63, 2));
         add_header(f, low, FILL_RANDOM);
      end
      total_bytes = byte_queue.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (byte_queue.size() != 0 || req_ch.valid) @(posedge clock);
      while (pending_headers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d header bytes, checked %0d headers (format 0/1/2/3: %0d/%0d/%0d/%0d)",
               bytes_sent, headers_checked, fmt_seen[0], fmt_seen[1], fmt_seen[2],
               fmt_seen[3]);
      $display("covered one- and two-byte channel extensions, sender and receiver gaps,");
      $display("and a %0d-cycle result stall", HOLD_CYCLES);
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+design
design/rtmp_chp_pkg.sv
design/rtmp_chp_req_if.sv
design/rtmp_chp_rsp_if.sv
design/rtmp_chp_decode.sv
design/rtmp_chp_outbuf.sv
design/rtmp_chunk_header_parser_top.sv
tb/rtmp_chunk_header_parser_top_tb.sv
